[src/slot_reel_text_reveal_defines.svh]
// Assertion helpers for the RTL of the reveal block.
`ifndef SLOT_REEL_TEXT_REVEAL_DEFINES_SVH
`define SLOT_REEL_TEXT_REVEAL_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SRTR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define SRTR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/srtr_pkg.sv]
package srtr_pkg;

  // Commands carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LOCK_DELAY = 2'd0,
    REG_SPIN_DELAY = 2'd1,
    REG_CELL_COUNT = 2'd2,
    REG_SEED       = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TGT_RD,
    ST_TGT_OUT,
    ST_RND_SHIFT,
    ST_RND_MUL,
    ST_RND_MOD
  } state_e;

  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [7:0]  RAND_BASE  = 8'h30;
  // 'Z' - '0' + 1
  localparam logic [6:0]  MOD_BASE   = 7'd43;
  // floor(2^37 / 43): quotient estimate is low by at most one
  localparam logic [31:0] MOD_RECIP  = 32'd3196254731;
  localparam int          MOD_SHIFT  = 37;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  localparam logic [15:0] LOCK_DELAY_RST = 16'd150;
  localparam logic [15:0] SPIN_DELAY_RST = 16'd50;
  localparam logic [4:0]  CELL_COUNT_RST = 5'd16;
  localparam logic [31:0] SEED_RST       = 32'd1;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

[src/slot_reel_text_reveal.sv]
// Slot-reel text reveal. Load beats (cmd 0) write a target character and dot
// into a per-cell store while the animation is idle; a start beat (cmd 1)
// restarts the animation from the leftmost cell; each tick beat (cmd 2) may
// lock one more cell to its target, refresh every unlocked cell with a random
// character, and, once all cells are locked, send the whole target frame with
// tuser set on its last beat. A tick that causes results is first accepted;
// then each target cell takes a registered store read and then an output
// load, and each random cell takes an xorshift step, a reciprocal multiply
// and a mod-43 correction before its output load, which the output side can
// stall. No new beat is taken until the last result of a tick is loaded
// into the output register. The store is cleared to spaces by per-cell
// valid bits, so no clearing pass follows reset.
`include "slot_reel_text_reveal_defines.svh"

module slot_reel_text_reveal #(
  parameter int DISPLAY_CELLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // cell_req[3:0], char_code[11:4], dot[12], zero[15:13]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_cell[3:0], out_char[11:4], out_dot[12], zero[15:13]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,  // finished[0]
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import srtr_pkg::*;

  localparam int CW = (DISPLAY_CELLS > 1) ? $clog2(DISPLAY_CELLS) : 1;
  localparam int PW = $clog2(DISPLAY_CELLS + 1);
  localparam int NW = (PW > 5) ? PW : 5;

  // configuration
  logic [15:0] lock_delay_q, spin_delay_q;
  logic [4:0]  cell_count_q;
  logic [31:0] seed_q;

  // animation state
  state_e        state_q, state_d;
  logic [PW-1:0] lp_q, lp_d;
  logic [15:0]   le_q, le_d, se_q, se_d;
  logic [31:0]   rand_q, rand_d;
  logic          done_q, done_d;
  logic [PW-1:0] ctr_q, ctr_d;
  logic [PW-1:0] cells_q, cells_d;
  logic          fin_ph_q, fin_ph_d;
  logic          spin_ne_q, spin_ne_d;
  logic          all_lk_q, all_lk_d;
  logic [31:0]   x_q, x_d;
  logic [63:0]   prod_q;

  // output register
  logic        out_vld_q, out_vld_d;
  logic [3:0]  out_cell_q, out_cell_d;
  logic [7:0]  out_char_q, out_char_d;
  logic        out_dot_q, out_dot_d;
  logic        out_last_q, out_last_d;
  logic        out_fin_q, out_fin_d;

  // cell store
  logic [8:0]             mem [DISPLAY_CELLS];
  logic [DISPLAY_CELLS-1:0] vld_q;
  logic                   wr_en;
  logic [CW-1:0]          wr_addr;
  logic                   rd_en;
  logic [CW-1:0]          rd_addr;
  logic [8:0]             rd_data_q;
  logic                   rd_vld_q;

  // decode
  logic          in_acc;
  logic [3:0]    cell_req;
  logic [7:0]    char_code;
  logic          dot;
  logic [CW+3:0] req_ext;
  logic [NW-1:0] cc_ext, cells_nw;
  logic [PW-1:0] cells_now;
  logic [15:0]   le_inc, se_inc;
  logic          lock_fire, spin_fire, spin_ne, all_lk;
  logic [PW-1:0] lp_new, ctr_inc;
  logic          out_free;
  logic [PW+3:0] ctr_ext;
  logic [26:0]   quo;
  logic [13:0]   qm;
  logic [6:0]    rem_raw, rem;
  logic [7:0]    tgt_char;
  logic          tgt_dot;

  assign cell_req  = s_axis_tdata[3:0];
  assign char_code = s_axis_tdata[11:4];
  assign dot       = s_axis_tdata[12];
  assign req_ext   = {{CW{1'b0}}, cell_req};
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_vld_q || m_axis_tready;
  assign ctr_ext   = {4'b0000, ctr_q};
  assign ctr_inc   = ctr_q + PW'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // live cell count, clamped to 1..DISPLAY_CELLS
  always_comb begin
    cc_ext = NW'(cell_count_q);
    if (cc_ext == '0) begin
      cells_nw = NW'(1);
    end else if (cc_ext > NW'(DISPLAY_CELLS)) begin
      cells_nw = NW'(DISPLAY_CELLS);
    end else begin
      cells_nw = cc_ext;
    end
    cells_now = cells_nw[PW-1:0];
  end

  // tick bookkeeping, evaluated on the accepted beat
  always_comb begin
    le_inc    = (le_q != CNT_MAX) ? le_q + 16'd1 : le_q;
    se_inc    = (se_q != CNT_MAX) ? se_q + 16'd1 : se_q;
    lock_fire = (le_inc >= lock_delay_q) && (lp_q < cells_now);
    lp_new    = lock_fire ? lp_q + PW'(1) : lp_q;
    spin_fire = (se_inc >= spin_delay_q);
    spin_ne   = spin_fire && (lp_new < cells_now);
    all_lk    = (lp_new >= cells_now);
  end

  // mod 43 by reciprocal estimate plus one correction
  always_comb begin
    quo     = prod_q[63:MOD_SHIFT];
    qm      = quo[6:0] * MOD_BASE;
    rem_raw = x_q[6:0] - qm[6:0];
    rem     = (rem_raw >= MOD_BASE) ? rem_raw - MOD_BASE : rem_raw;
  end

  assign tgt_char = rd_vld_q ? rd_data_q[7:0] : SPACE_CHAR;
  assign tgt_dot  = rd_vld_q && rd_data_q[8];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == CMD_TICK) && !done_q) begin
          if (lock_fire || all_lk) begin
            state_d = ST_TGT_RD;
          end else if (spin_ne) begin
            state_d = ST_RND_SHIFT;
          end
        end
      end
      ST_TGT_RD: state_d = ST_TGT_OUT;
      ST_TGT_OUT: begin
        if (out_free) begin
          if (fin_ph_q) begin
            state_d = (ctr_inc < cells_q) ? ST_TGT_RD : ST_IDLE;
          end else if (spin_ne_q) begin
            state_d = ST_RND_SHIFT;
          end else if (all_lk_q) begin
            state_d = ST_TGT_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RND_SHIFT: state_d = ST_RND_MUL;
      ST_RND_MUL:   state_d = ST_RND_MOD;
      ST_RND_MOD: begin
        if (out_free) begin
          if (ctr_inc < cells_q) begin
            state_d = ST_RND_SHIFT;
          end else if (all_lk_q) begin
            state_d = ST_TGT_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lp_d        = lp_q;
    le_d        = le_q;
    se_d        = se_q;
    rand_d      = rand_q;
    done_d      = done_q;
    ctr_d       = ctr_q;
    cells_d     = cells_q;
    fin_ph_d    = fin_ph_q;
    spin_ne_d   = spin_ne_q;
    all_lk_d    = all_lk_q;
    x_d         = x_q;
    wr_en       = 1'b0;
    wr_addr     = req_ext[CW-1:0];
    rd_en       = 1'b0;
    rd_addr     = ctr_q[CW-1:0];
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_cell_d  = out_cell_q;
    out_char_d  = out_char_q;
    out_dot_d   = out_dot_q;
    out_last_d  = out_last_q;
    out_fin_d   = out_fin_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            CMD_LOAD: begin
              wr_en = done_q && (32'(cell_req) < 32'(DISPLAY_CELLS));
            end
            CMD_START: begin
              le_d   = '0;
              se_d   = '0;
              lp_d   = '0;
              rand_d = seed_q | 32'd1;
              done_d = 1'b0;
            end
            CMD_TICK: begin
              if (!done_q) begin
                le_d        = lock_fire ? '0 : le_inc;
                se_d        = spin_fire ? '0 : se_inc;
                lp_d        = lp_new;
                done_d      = all_lk;
                cells_d     = cells_now;
                spin_ne_d   = spin_ne;
                all_lk_d    = all_lk;
                if (lock_fire) begin
                  ctr_d    = lp_q;
                  fin_ph_d = 1'b0;
                end else if (spin_ne) begin
                  ctr_d = lp_new;
                end else begin
                  ctr_d    = '0;
                  fin_ph_d = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_TGT_RD: begin
        rd_en = 1'b1;
      end
      ST_TGT_OUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_cell_d = ctr_ext[3:0];
          out_char_d = tgt_char;
          out_dot_d  = tgt_dot;
          if (fin_ph_q) begin
            out_last_d = !(ctr_inc < cells_q);
            out_fin_d  = !(ctr_inc < cells_q);
            ctr_d      = ctr_inc;
          end else begin
            // locked cell: spin or final frame may follow
            out_last_d = !spin_ne_q && !all_lk_q;
            out_fin_d  = 1'b0;
            if (spin_ne_q) begin
              ctr_d = lp_q;
            end else begin
              ctr_d    = '0;
              fin_ph_d = 1'b1;
            end
          end
        end
      end
      ST_RND_SHIFT: begin
        x_d    = xorshift32(rand_q);
        rand_d = x_d;
      end
      ST_RND_MUL: ;
      ST_RND_MOD: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_cell_d = ctr_ext[3:0];
          out_char_d = RAND_BASE + {1'b0, rem};
          out_dot_d  = 1'b0;
          out_last_d = !(ctr_inc < cells_q) && !all_lk_q;
          out_fin_d  = 1'b0;
          if (ctr_inc < cells_q) begin
            ctr_d = ctr_inc;
          end else begin
            ctr_d    = '0;
            fin_ph_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_delay_q <= LOCK_DELAY_RST;
      spin_delay_q <= SPIN_DELAY_RST;
      cell_count_q <= CELL_COUNT_RST;
      seed_q       <= SEED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LOCK_DELAY: lock_delay_q <= cfg_data_i[15:0];
        REG_SPIN_DELAY: spin_delay_q <= cfg_data_i[15:0];
        REG_CELL_COUNT: cell_count_q <= cfg_data_i[4:0];
        REG_SEED:       seed_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lp_q        <= '0;
      le_q        <= '0;
      se_q        <= '0;
      rand_q      <= 32'd1;
      done_q      <= 1'b1;
      ctr_q       <= '0;
      cells_q     <= '0;
      fin_ph_q    <= 1'b0;
      spin_ne_q   <= 1'b0;
      all_lk_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      lp_q        <= lp_d;
      le_q        <= le_d;
      se_q        <= se_d;
      rand_q      <= rand_d;
      done_q      <= done_d;
      ctr_q       <= ctr_d;
      cells_q     <= cells_d;
      fin_ph_q    <= fin_ph_d;
      spin_ne_q   <= spin_ne_d;
      all_lk_q    <= all_lk_d;
      out_vld_q   <= out_vld_d;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    prod_q     <= x_q * MOD_RECIP;
    out_cell_q <= out_cell_d;
    out_char_q <= out_char_d;
    out_dot_q  <= out_dot_d;
    out_last_q <= out_last_d;
    out_fin_q  <= out_fin_d;
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {dot, char_code};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_dot_q, out_char_q, out_cell_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fin_q;

  `SRTR_ASSERT_IMPLY(a_fin_is_last, out_vld_q && out_fin_q, out_last_q, "finished beat without tlast")
  `SRTR_ASSERT_ALWAYS(a_lp_range, 32'(lp_q) <= DISPLAY_CELLS, "lock pointer beyond display")
  `SRTR_ASSERT_IMPLY(a_rd_range, state_q == ST_TGT_RD, 32'(ctr_q) < DISPLAY_CELLS, "store read out of range")
  `SRTR_ASSERT_IMPLY(a_spin_unlocked, state_q == ST_RND_SHIFT, ctr_q >= lp_q, "spinning a locked cell")
  `SRTR_ASSERT_IMPLY(a_final_done, state_q == ST_TGT_RD && fin_ph_q, done_q, "final frame while not done")
  `SRTR_ASSERT_IMPLY(a_rand_nonzero, !done_q, rand_q != 32'd0, "generator state stuck at zero")

endmodule

[test/reveal_frame_checker.sv]
`timescale 1ns / 100ps

module reveal_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_tvalid_i,
  input  logic        in_tready_i,
  input  logic [15:0] in_tdata_i,   // cell_req[3:0], char_code[11:4], dot[12], zero[15:13]
  input  logic [1:0]  in_tuser_i,   // cmd[1:0]
  input  logic        out_tvalid_i,
  input  logic        out_tready_i,
  input  logic [15:0] out_tdata_i,  // out_cell[3:0], out_char[11:4], out_dot[12], zero[15:13]
  input  logic        out_tlast_i,
  input  logic        out_tuser_i,  // finished[0]
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pend_cnt_o
);
  import srtr_pkg::*;

  localparam int NCELLS    = 16;
  localparam int FRAME_MAX = 2 * NCELLS + 1;
  localparam int EXP_DEPTH = 64;

  typedef struct packed {
    logic [3:0] pos;
    logic [7:0] ch;
    logic       dot;
    logic       last;
    logic       fin;
  } cell_write_t;

  // register copies
  logic [15:0] lock_dly;
  logic [15:0] spin_dly;
  logic [4:0]  cell_cnt;
  logic [31:0] seed_r;

  // animation state
  logic [7:0]  tgt_char [NCELLS];
  logic        tgt_dot  [NCELLS];
  logic [4:0]  lock_ptr;
  logic [15:0] lock_el;
  logic [15:0] spin_el;
  logic [31:0] rng;
  logic        idle;

  // expected cell writes, oldest at exp_head
  cell_write_t exp_mem [EXP_DEPTH];
  int          exp_head;
  int          exp_tail;
  int          exp_fill;
  cell_write_t got_w;
  cell_write_t want_w;

  task automatic add_expect(input cell_write_t w);
    exp_mem[exp_tail] = w;
    exp_tail = (exp_tail + 1) % EXP_DEPTH;
    exp_fill++;
  endtask

  task automatic take_expect(output cell_write_t w);
    w = exp_mem[exp_head];
    exp_head = (exp_head + 1) % EXP_DEPTH;
    exp_fill--;
  endtask

  task automatic flag_result(input string why, input cell_write_t want, input cell_write_t got);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) begin
      $display("%0t: %s", $realtime, why);
      $display("  want cell %0d char %h dot %b last %b fin %b",
               want.pos, want.ch, want.dot, want.last, want.fin);
      $display("  got  cell %0d char %h dot %b last %b fin %b",
               got.pos, got.ch, got.dot, got.last, got.fin);
    end
  endtask

  // Advance the reveal by one input beat and queue the cell writes it causes.
  task automatic step_reel(input cmd_e cmd, input logic [15:0] d);
    cell_write_t frame [FRAME_MAX];
    cell_write_t w;
    logic [31:0] x;
    int          cells;
    int          i;
    int          nres;
    bit          all_locked;
    all_locked = 1'b0;
    nres       = 0;
    case (cmd)
      CMD_LOAD: begin
        if (idle) begin
          tgt_char[d[3:0]] = d[11:4];
          tgt_dot[d[3:0]]  = d[12];
        end
      end
      CMD_START: begin
        lock_el  = '0;
        spin_el  = '0;
        lock_ptr = '0;
        rng      = seed_r | 32'd1;
        idle     = 1'b0;
      end
      CMD_TICK: begin
        if (!idle) begin
          if (lock_el != CNT_MAX) lock_el++;
          if (spin_el != CNT_MAX) spin_el++;
          // cell count is read live and clamped to 1..NCELLS
          cells = (cell_cnt == 0) ? 1 : (cell_cnt > NCELLS) ? NCELLS : int'(cell_cnt);
          if (lock_el >= lock_dly && lock_ptr < cells) begin
            w = '{pos: lock_ptr[3:0], ch: tgt_char[lock_ptr[3:0]],
                  dot: tgt_dot[lock_ptr[3:0]], last: 1'b0, fin: 1'b0};
            frame[nres] = w;
            nres++;
            lock_ptr++;
            lock_el = '0;
          end
          if (spin_el >= spin_dly) begin
            for (i = int'(lock_ptr); i < cells; i++) begin
              x = rng;
              x = x ^ (x << 13);
              x = x ^ (x >> 17);
              x = x ^ (x << 5);
              rng = x;
              w = '{pos: i[3:0], ch: RAND_BASE + 8'(x % MOD_BASE), dot: 1'b0,
                    last: 1'b0, fin: 1'b0};
              frame[nres] = w;
              nres++;
            end
            spin_el = '0;
          end
          if (lock_ptr >= cells) begin
            for (i = 0; i < cells; i++) begin
              w = '{pos: i[3:0], ch: tgt_char[i], dot: tgt_dot[i], last: 1'b0, fin: 1'b0};
              frame[nres] = w;
              nres++;
            end
            idle = 1'b1;
            all_locked = 1'b1;
          end
          for (i = 0; i < nres; i++) begin
            w = frame[i];
            w.last = (i == nres - 1);
            w.fin  = all_locked && w.last;
            add_expect(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_dly = LOCK_DELAY_RST;
      spin_dly = SPIN_DELAY_RST;
      cell_cnt = CELL_COUNT_RST;
      seed_r   = SEED_RST;
      for (int c = 0; c < NCELLS; c++) begin
        tgt_char[c] = SPACE_CHAR;
        tgt_dot[c]  = 1'b0;
      end
      lock_ptr = '0;
      lock_el  = '0;
      spin_el  = '0;
      rng      = 32'd1;
      idle     = 1'b1;
      exp_head = 0;
      exp_tail = 0;
      exp_fill = 0;
      fail_cnt_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_LOCK_DELAY: lock_dly = cfg_data_i[15:0];
          REG_SPIN_DELAY: spin_dly = cfg_data_i[15:0];
          REG_CELL_COUNT: cell_cnt = cfg_data_i[4:0];
          REG_SEED:       seed_r   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_tvalid_i && out_tready_i) begin
        got_w = '{pos: out_tdata_i[3:0], ch: out_tdata_i[11:4], dot: out_tdata_i[12],
                  last: out_tlast_i, fin: out_tuser_i};
        if (exp_fill == 0) begin
          want_w = 'x;
          flag_result("unexpected beat", want_w, got_w);
        end else begin
          take_expect(want_w);
          if (got_w !== want_w) flag_result("mismatch", want_w, got_w);
        end
      end
      if (in_tvalid_i && in_tready_i) step_reel(cmd_e'(in_tuser_i), in_tdata_i);
    end
    pend_cnt_o = exp_fill;
  end

endmodule

[test/tb_slot_reel_text_reveal.sv]
`timescale 1ns / 100ps

module tb_slot_reel_text_reveal;
  import srtr_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 60;
  localparam int RANDOM_ITEMS = 290;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // cell_req[3:0], char_code[11:4], dot[12], zero[15:13]
  logic [1:0]  s_axis_tuser;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // out_cell[3:0], out_char[11:4], out_dot[12], zero[15:13]
  logic        m_axis_tlast;
  logic        m_axis_tuser;   // finished[0]
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int fail_cnt;
  int pend_cnt;
  int sent;
  bit tx_burst;

  slot_reel_text_reveal dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  reveal_frame_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .out_tlast_i  (m_axis_tlast),
    .out_tuser_i  (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_cnt_o   (fail_cnt),
    .pend_cnt_o   (pend_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Called and returning at a falling edge; valid stays up when the next gap is zero.
  task automatic send_item(input cmd_e cmd, input logic [3:0] pos, input logic [7:0] ch,
                           input logic dot);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, dot, ch, pos};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_cmd(input cmd_e cmd);
    send_item(cmd, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  // Hold off until every queued cell write is out and the block has drained.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic put_reg(input reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] lock_d, input logic [15:0] spin_d,
                              input logic [4:0] cells, input logic [31:0] seed_v);
    quiesce();
    put_reg(REG_LOCK_DELAY, {16'd0, lock_d});
    put_reg(REG_SPIN_DELAY, {16'd0, spin_d});
    put_reg(REG_CELL_COUNT, {27'd0, cells});
    put_reg(REG_SEED, seed_v);
    cfg_valid_i <= 1'b0;
  endtask

  // result side backpressure
  initial begin
    bit took;
    bit rx_burst;
    int stall;
    m_axis_tready = 1'b0;
    rx_burst = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      took = m_axis_tvalid && m_axis_tready;
      @(negedge clk_i);
      if (took) begin
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ends the run when no beat moves on any channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [15:0] lock_d;
    logic [15:0] spin_d;
    logic [4:0]  cells;
    logic [31:0] seed_v;
    int          ncell;
    int          nticks;
    int          base;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_NONE;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_LOCK_DELAY;
    cfg_data_i    = '0;
    sent          = 0;
    tx_burst      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle block ignores ticks and the spare command
    send_cmd(CMD_TICK);
    send_cmd(CMD_NONE);
    send_item(CMD_LOAD, 4'd0, 8'hFF, 1'b1);
    send_item(CMD_LOAD, 4'd15, 8'h00, 1'b0);
    send_item(CMD_LOAD, 4'd5, 8'h41, 1'b1);
    send_item(CMD_LOAD, 4'd10, 8'h7F, 1'b0);
    // reset delays: a few ticks stay silent
    send_cmd(CMD_START);
    repeat (3) send_cmd(CMD_TICK);

    program_regs(16'd0, 16'd0, 5'd3, 32'd0);
    send_cmd(CMD_START);
    send_cmd(CMD_TICK);
    send_item(CMD_LOAD, 4'd1, 8'h55, 1'b1);  // dropped while animating
    send_cmd(CMD_START);                     // restart from the left
    repeat (3) send_cmd(CMD_TICK);

    // zero cells clamps to one
    program_regs(16'd1, 16'hFFFF, 5'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_START);
    repeat (2) send_cmd(CMD_TICK);

    // oversize cell count clamps to all cells; locks never come due
    program_regs(16'hFFFF, 16'd1, 5'd31, 32'h1234_5678);
    send_cmd(CMD_START);
    repeat (3) send_cmd(CMD_TICK);
    program_regs(16'd0, 16'd1, 5'd16, 32'h1234_5678);
    repeat (3) send_cmd(CMD_TICK);
    // shrink below the lock pointer mid-run: final frame right away
    program_regs(16'd0, 16'd1, 5'd2, 32'h1234_5678);
    send_cmd(CMD_TICK);

    base = sent;
    while (sent < base + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       lock_d = 16'hFFFF;
        1:       lock_d = 16'($urandom_range(3, 65535));
        default: lock_d = 16'($urandom_range(0, 2));
      endcase
      case ($urandom_range(0, 9))
        0:       spin_d = 16'hFFFF;
        1:       spin_d = 16'($urandom_range(5, 65535));
        default: spin_d = 16'($urandom_range(0, 4));
      endcase
      case ($urandom_range(0, 7))
        0:       cells = 5'd0;
        1:       cells = 5'($urandom_range(16, 31));
        2:       cells = 5'($urandom_range(7, 16));
        default: cells = 5'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 5))
        0:       seed_v = 32'd0;
        1:       seed_v = 32'hFFFF_FFFF;
        default: seed_v = $urandom;
      endcase
      program_regs(lock_d, spin_d, cells, seed_v);

      repeat ($urandom_range(0, 4)) send_item(CMD_LOAD, 4'($urandom_range(0, 15)),
                                              8'($urandom_range(0, 255)),
                                              1'($urandom_range(0, 1)));
      send_cmd(CMD_START);
      ncell  = (cells == 0) ? 1 : (cells > 16) ? 16 : int'(cells);
      nticks = ncell * (int'(lock_d) + 1) + $urandom_range(0, 3);
      if (nticks > 40) nticks = 40;
      repeat (nticks) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0:       send_cmd(CMD_LOAD);
            1:       send_cmd(CMD_START);
            default: send_cmd(CMD_NONE);
          endcase
        end else begin
          send_cmd(CMD_TICK);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (fail_cnt == 0 && pend_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
